### sv/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### sv/upss_pkg.sv
// ----------------------------------------------------------------------------
// upss_pkg
// Shared types and constants of the urgency priority stream scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package upss_pkg;
  localparam int SLOT_COUNT  = 64;
  localparam int LEVEL_COUNT = 8;
  localparam int SW = $clog2(SLOT_COUNT);
  localparam int LW = $clog2(LEVEL_COUNT);
  localparam int PW = SW + 1;
  localparam logic [2:0] URG_DEFAULT = 3'd3;
  localparam logic [3:0] URG_MAX = 4'd7;
  localparam logic [LW-1:0] DEF_LEVEL =
    (3 < LEVEL_COUNT) ? LW'(3) : LW'(LEVEL_COUNT - 1);
  localparam logic [PW-1:0] NO_SLOT = PW'(SLOT_COUNT);

  typedef enum logic [2:0] {
    FN_ADD = 3'd0, FN_REMOVE = 3'd1, FN_PICK = 3'd2, FN_SETPRI = 3'd3, FN_SETOPEN = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0, ST_NOCHG = 2'd1, ST_REJECT = 2'd2, ST_NONE = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0] func;
    logic [5:0] stream_slot;
    logic [3:0] new_urgency;
    logic       new_incremental;
    logic       open_flag;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       chosen_valid;
    logic [5:0] chosen_slot;
    logic [2:0] slot_urgency;
    logic       slot_incremental;
  } rsp_t;

  // Datapath commands
  typedef enum logic [3:0] {
    C_NOP, C_LOAD, C_ULINK_A, C_ULINK_B, C_APP_A, C_APP_B, C_FLAGS,
    C_SCAN_LV, C_SCAN_RD, C_SCAN_STEP, C_PICKED, C_RESULT
  } cmd_t;

  typedef struct packed {
    logic [2:0] fn;
    logic in_range;
    logic queued;
    logic reject;
    logic urg_change;
    logic incr;
    logic scan_hit;
    logic scan_end;
    logic lv_last;
  } stat_t;

  function automatic logic [LW-1:0] level_of(input logic [2:0] u);
    if (32'(u) < LEVEL_COUNT) return LW'(u);
    return DEF_LEVEL;
  endfunction
endpackage

### sv/upss_if.sv
// ----------------------------------------------------------------------------
// upss_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface upss_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/upss_datapath.sv
// ----------------------------------------------------------------------------
// upss_datapath
// Slot tables, link memories, level heads/tails and result assembly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module upss_datapath import upss_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cmd_t  cmd,
  input  req_t  req,
  output stat_t st,
  output rsp_t  rsp
);
  logic [2:0]    urg_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] urg_set_r;
  logic [SLOT_COUNT-1:0] inc_r, que_r, opn_r;
  logic [PW-1:0] nxt_mem [SLOT_COUNT];
  logic [PW-1:0] prv_mem [SLOT_COUNT];
  logic [PW-1:0] head_r [LEVEL_COUNT];
  logic [PW-1:0] tail_r [LEVEL_COUNT];

  req_t          req_r;
  logic [SW-1:0] s_r;
  logic [LW-1:0] lv_r;
  logic [PW-1:0] cur_r, p_r, n_r;
  logic [SW:0]   guard_r;
  logic          found_r;
  logic          que0_r;
  logic [2:0]    urg_rd_r;
  logic          urg_hit_r;
  rsp_t          rsp_r;

  logic [LW-1:0] old_lv, new_lv;
  logic [SW-1:0] cur_s;
  logic [2:0]    urg_cur;
  assign cur_s   = cur_r[SW-1:0];
  assign urg_cur = urg_hit_r ? urg_rd_r : URG_DEFAULT;
  assign old_lv  = level_of(urg_cur);
  assign new_lv  = level_of(req_r.new_urgency[2:0]);

  assign st.fn         = req_r.func;
  assign st.in_range   = 32'(req_r.stream_slot) < SLOT_COUNT;
  assign st.queued     = que_r[s_r];
  assign st.reject     = req_r.new_urgency > URG_MAX;
  assign st.urg_change = {1'b0, urg_cur} != req_r.new_urgency;
  assign st.incr       = inc_r[s_r];
  assign st.scan_hit   = (cur_r < NO_SLOT) && (guard_r < (SW+1)'(SLOT_COUNT))
                         && opn_r[cur_s];
  assign st.scan_end   = !(cur_r < NO_SLOT) || !(guard_r < (SW+1)'(SLOT_COUNT));
  assign st.lv_last    = 32'(lv_r) == LEVEL_COUNT - 1;
  assign rsp = rsp_r;

  // Append target level: pick keeps its level, set priority uses new level, others use current level
  logic [LW-1:0] app_lv;
  assign app_lv = (req_r.func == FN_SETPRI) ? new_lv :
                  (req_r.func == FN_PICK) ? lv_r : old_lv;
  logic [LW-1:0] ul_lv;
  assign ul_lv = (req_r.func == FN_PICK) ? lv_r : old_lv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      urg_set_r <= '0;
      inc_r <= '0;
      que_r <= '0;
      opn_r <= '0;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        head_r[i] <= NO_SLOT;
        tail_r[i] <= NO_SLOT;
      end
    end else begin
      unique case (cmd)
        C_LOAD: begin
          req_r <= req;
          s_r   <= SW'(req.stream_slot);
          lv_r  <= '0;
          found_r <= 1'b0;
          que0_r  <= que_r[req.stream_slot];
          urg_rd_r  <= urg_mem[req.stream_slot];
          urg_hit_r <= urg_set_r[req.stream_slot];
        end
        C_ULINK_A: begin
          p_r <= prv_mem[s_r];
          n_r <= nxt_mem[s_r];
        end
        C_ULINK_B: begin
          if (p_r < NO_SLOT) nxt_mem[p_r[SW-1:0]] <= n_r;
          else head_r[ul_lv] <= n_r;
          if (n_r < NO_SLOT) prv_mem[n_r[SW-1:0]] <= p_r;
          else tail_r[ul_lv] <= p_r;
        end
        C_APP_A: begin
          prv_mem[s_r] <= tail_r[app_lv];
          nxt_mem[s_r] <= NO_SLOT;
          p_r <= tail_r[app_lv];
        end
        C_APP_B: begin
          if (p_r < NO_SLOT) nxt_mem[p_r[SW-1:0]] <= {1'b0, s_r};
          else head_r[app_lv] <= {1'b0, s_r};
          tail_r[app_lv] <= {1'b0, s_r};
        end
        C_FLAGS: begin
          unique case (req_r.func)
            FN_ADD:    que_r[s_r] <= 1'b1;
            FN_REMOVE: que_r[s_r] <= 1'b0;
            FN_SETPRI: begin
              urg_mem[s_r]   <= req_r.new_urgency[2:0];
              urg_set_r[s_r] <= 1'b1;
              urg_rd_r       <= req_r.new_urgency[2:0];
              urg_hit_r      <= 1'b1;
              inc_r[s_r]     <= req_r.new_incremental;
            end
            FN_SETOPEN: opn_r[s_r] <= req_r.open_flag;
            default: ;
          endcase
        end
        C_SCAN_LV: begin
          cur_r   <= head_r[lv_r];
          guard_r <= '0;
        end
        C_SCAN_RD: begin
          cur_r   <= nxt_mem[cur_s];
          guard_r <= guard_r + 1'b1;
        end
        C_SCAN_STEP: lv_r <= lv_r + 1'b1;
        C_PICKED: begin
          s_r <= cur_s;
          found_r <= 1'b1;
          urg_rd_r  <= urg_mem[cur_s];
          urg_hit_r <= urg_set_r[cur_s];
        end
        C_RESULT: begin
          if (req_r.func == FN_PICK) begin
            rsp_r.status       <= found_r ? ST_DONE : ST_NONE;
            rsp_r.chosen_valid <= found_r;
            rsp_r.chosen_slot  <= found_r ? 6'(s_r) : 6'd0;
          end else begin
            rsp_r.chosen_valid <= 1'b0;
            rsp_r.chosen_slot  <= 6'd0;
            if (!st.in_range) rsp_r.status <= ST_NOCHG;
            else begin
              case (req_r.func)
                FN_ADD:     rsp_r.status <= que0_r ? ST_NOCHG : ST_DONE;
                FN_REMOVE:  rsp_r.status <= que0_r ? ST_DONE : ST_NOCHG;
                FN_SETPRI:  rsp_r.status <= st.reject ? ST_REJECT : ST_DONE;
                FN_SETOPEN: rsp_r.status <= ST_DONE;
                default:    rsp_r.status <= ST_NOCHG;
              endcase
            end
          end
          if (found_r || st.in_range) begin
            rsp_r.slot_urgency     <= urg_cur;
            rsp_r.slot_incremental <= inc_r[s_r];
          end else begin
            rsp_r.slot_urgency     <= URG_DEFAULT;
            rsp_r.slot_incremental <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### sv/upss_ctrl.sv
// ----------------------------------------------------------------------------
// upss_ctrl
// Sequencer driving the datapath through one operation at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module upss_ctrl import upss_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output cmd_t  cmd
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001, S_DEC   = 11'b00000000010,
    S_UL_A  = 11'b00000000100, S_UL_B  = 11'b00000001000,
    S_AP_A  = 11'b00000010000, S_AP_B  = 11'b00000100000,
    S_FLAG  = 11'b00001000000, S_LV    = 11'b00010000000,
    S_WALK  = 11'b00100000000, S_RES   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   move_r, move_nxt, pick_r, pick_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    move_nxt  = move_r;
    pick_nxt  = pick_r;
    cmd       = C_NOP;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd = C_LOAD;
        pick_nxt = 1'b0;
        move_nxt = 1'b0;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        pick_nxt = 1'b0;
        move_nxt = 1'b0;
        state_nxt = S_RES;
        if (st.fn == FN_PICK) state_nxt = S_LV;
        else if (st.in_range) begin
          case (st.fn)
            FN_ADD: if (!st.queued) state_nxt = S_AP_A;
            FN_REMOVE: if (st.queued) state_nxt = S_UL_A;
            FN_SETPRI: if (!st.reject) begin
              state_nxt = S_FLAG;
              if (st.queued && st.urg_change) begin
                move_nxt = 1'b1;
                state_nxt = S_UL_A;
              end
            end
            FN_SETOPEN: state_nxt = S_FLAG;
            default: ;
          endcase
        end
      end
      S_UL_A: begin cmd = C_ULINK_A; state_nxt = S_UL_B; end
      S_UL_B: begin
        cmd = C_ULINK_B;
        state_nxt = (move_r || pick_r) ? S_AP_A : S_FLAG;
      end
      S_AP_A: begin cmd = C_APP_A; state_nxt = S_AP_B; end
      S_AP_B: begin
        cmd = C_APP_B;
        state_nxt = pick_r ? S_RES : S_FLAG;
      end
      S_FLAG: begin cmd = C_FLAGS; state_nxt = S_RES; end
      S_LV: begin cmd = C_SCAN_LV; state_nxt = S_WALK; end
      S_WALK: begin
        if (st.scan_hit) begin
          cmd = C_PICKED;
          pick_nxt = 1'b1;
          state_nxt = S_DEC;
        end else if (st.scan_end) begin
          cmd = C_SCAN_STEP;
          state_nxt = st.lv_last ? S_RES : S_LV;
        end else cmd = C_SCAN_RD;
      end
      S_RES: begin cmd = C_RESULT; state_nxt = S_OUT; end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // after a hit, route through unlink/append if incremental
    if (state_r == S_DEC && pick_r) begin
      pick_nxt  = 1'b1;
      state_nxt = st.incr ? S_UL_A : S_RES;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      move_r  <= 1'b0;
      pick_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      move_r  <= move_nxt;
      pick_r  <= pick_nxt;
    end
  end
endmodule

### sv/urgency_priority_stream_scheduler_unit.sv
// ----------------------------------------------------------------------------
// urgency_priority_stream_scheduler_unit
// Strict-priority stream scheduler with round robin among incremental streams within each level.
// ----------------------------------------------------------------------------
// One item at a time: add, remove, set priority and set open flag run through
// decode, optional unlink and append steps and a flag update before the result;
// pick next walks the level lists one link-memory read per cycle, and an
// incremental picked slot then moves to its list tail.
`timescale 1ns / 1ps
module urgency_priority_stream_scheduler_unit import upss_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  upss_if.sink   in_ch,
  upss_if.source out_ch
);
  cmd_t  cmd;
  stat_t st;
  rsp_t  rsp;
  req_t  req;

  assign req = in_ch.data;

  upss_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .st, .cmd
  );

  upss_datapath u_dp (.clk, .rst_n, .cmd, .req, .st, .rsp);

  assign out_ch.data = rsp;
endmodule

### sv/upss_checker.sv
// ----------------------------------------------------------------------------
// upss_checker
// Port-level checks of the scheduler's request and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module upss_checker import upss_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);
  `ASSERT_IMPL(a_one_side, in_ready, !out_valid)
  `ASSERT_IMPL(a_pick_slot, out_valid && !out_data.chosen_valid, out_data.chosen_slot == 6'd0)
  `ASSERT_IMPL(a_none_st, out_valid && out_data.status == ST_NONE, !out_data.chosen_valid)
  `ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind urgency_priority_stream_scheduler_unit upss_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
